// ===== design/wcc_pkg.sv =====
// Washer controller package: operation codes, motor levels, register indexes
// and reset values. No dependencies.

package wcc_pkg;

   localparam int TIME_BITS_DEFAULT = 10;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int OP_BITS           = 4;
   localparam int LEVEL_BITS        = 2;

   localparam int SHORT_TIME_RESET  = 15;
   localparam int MEDIUM_TIME_RESET = 30;
   localparam int LONG_TIME_RESET   = 45;
   localparam int CYCLE_TIME_RESET  = 30;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK          = 4'd0,
      OP_SELECT_CYCLE  = 4'd1,
      OP_TOGGLE_DOOR   = 4'd2,
      OP_OPEN_DOOR     = 4'd3,
      OP_CLOSE_DOOR    = 4'd4,
      OP_FILL          = 4'd5,
      OP_ABORT         = 4'd6,
      OP_START         = 4'd7,
      OP_PAUSE         = 4'd8,
      OP_RESUME        = 4'd9,
      OP_PAUSE_SWITCH  = 4'd10,
      OP_SET_TIME      = 4'd11
   } op_type;

   typedef enum logic [LEVEL_BITS-1:0] {
      LVL_OFF  = 2'd0,
      LVL_LOW  = 2'd1,
      LVL_MED  = 2'd2,
      LVL_FULL = 2'd3
   } level_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SHORT_TIME  = 2'd0,
      CSR_MEDIUM_TIME = 2'd1,
      CSR_LONG_TIME   = 2'd2
   } csr_index_type;

endpackage

// ===== design/wash_cycle_controller_top.sv =====
// Washer controller top level: request register, event and main-loop logic,
// response register. Depends on wcc_pkg.
//
// An accepted request enters the request register; its response enters the
// response register once that is empty or its response is taken. Throughput:
// one request per cycle while responses are taken; the state update is a single
// pass of flag logic and constant-multiple compares between the two registers.
// Reset (synchronous, active high): flags clear, door open, times load 30,
// cycle table loads 15/30/45, table index 0, motor off, both registers empty.

module wash_cycle_controller_top #(
   parameter int TIME_BITS = wcc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [wcc_pkg::OP_BITS-1:0]          req_operation,
   input  logic [TIME_BITS-1:0]                 req_new_time,
   // responses
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wcc_pkg::LEVEL_BITS-1:0]       rsp_motor_level,
   output logic                                 rsp_running,
   output logic                                 rsp_door_closed,
   output logic                                 rsp_detergent_filled,
   output logic                                 rsp_aborted,
   output logic                                 rsp_completed,
   output logic signed [TIME_BITS:0]            rsp_time_left,
   output logic [TIME_BITS-1:0]                 rsp_total_time,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [TIME_BITS-1:0]                 csr_data
);

   localparam int PROD_BITS = TIME_BITS + 4;

   // cycle table
   logic [TIME_BITS-1:0] short_time_ff, medium_time_ff, long_time_ff;

   // request register
   logic                         in_vld_ff, in_vld_in;
   logic [wcc_pkg::OP_BITS-1:0]  in_op_ff;
   logic [TIME_BITS-1:0]         in_time_ff;

   // controller state
   logic                         door_ff, door_in;
   logic                         fill_ff, fill_in;
   logic                         run_ff, run_in;
   logic                         abort_ff, abort_in;
   logic                         done_ff, done_in;
   logic signed [TIME_BITS:0]    rem_ff, rem_in;
   logic [TIME_BITS-1:0]         cyc_ff, cyc_in;
   logic [1:0]                   idx_ff, idx_in;
   logic [wcc_pkg::LEVEL_BITS-1:0] lvl_ff, lvl_in;

   // response register
   logic                         rsp_vld_ff, rsp_vld_in;

   logic                         advance;
   logic [1:0]                   sel_idx;
   logic                         rem_pos, rem_zero;
   logic [PROD_BITS-1:0]         rem_x10, cyc_x7, cyc_x2;

   assign csr_ready = 1'b1;
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // event first, then the main-loop rule
   always_comb begin
      door_in  = door_ff;
      fill_in  = fill_ff;
      run_in   = run_ff;
      abort_in = abort_ff;
      done_in  = done_ff;
      rem_in   = rem_ff;
      cyc_in   = cyc_ff;
      idx_in   = idx_ff;
      lvl_in   = lvl_ff;
      sel_idx  = (idx_ff == 2'd3) ? 2'd0 : idx_ff;

      case (in_op_ff)
         wcc_pkg::OP_TICK: begin
            if (!abort_ff && run_ff && !rem_ff[TIME_BITS] && (rem_ff != '0)) begin
               rem_in = rem_ff - 1'b1;
            end
         end
         wcc_pkg::OP_SELECT_CYCLE: begin
            if (!abort_ff) begin
               case (sel_idx)
                  2'd0:    cyc_in = short_time_ff;
                  2'd1:    cyc_in = medium_time_ff;
                  default: cyc_in = long_time_ff;
               endcase
               rem_in = $signed({1'b0, cyc_in});
               idx_in = sel_idx + 2'd1;
            end
         end
         wcc_pkg::OP_TOGGLE_DOOR: begin
            if (!abort_ff && !run_ff) door_in = !door_ff;
         end
         wcc_pkg::OP_OPEN_DOOR: begin
            if (!run_ff) door_in = 1'b0;
         end
         wcc_pkg::OP_CLOSE_DOOR: begin
            door_in = 1'b1;
         end
         wcc_pkg::OP_FILL: begin
            if (!abort_ff && !door_ff && !run_ff) fill_in = 1'b1;
         end
         wcc_pkg::OP_ABORT: begin
            abort_in = 1'b1;
            run_in   = 1'b0;
            rem_in   = '0;
         end
         wcc_pkg::OP_START: begin
            if (!done_ff && !abort_ff && fill_ff && door_ff) run_in = 1'b1;
         end
         wcc_pkg::OP_PAUSE: begin
            if (!abort_ff) run_in = 1'b0;
         end
         wcc_pkg::OP_RESUME: begin
            if (!abort_ff && fill_ff && door_ff) run_in = 1'b1;
         end
         wcc_pkg::OP_PAUSE_SWITCH: begin
            if (run_ff) begin
               run_in = 1'b0;
            end else if (!abort_ff && fill_ff && door_ff) begin
               run_in = 1'b1;
            end
         end
         wcc_pkg::OP_SET_TIME: begin
            cyc_in = in_time_ff;
            rem_in = $signed({1'b0, in_time_ff});
         end
         default: ;
      endcase

      // 10*rem against 7*total and 2*total, exact
      rem_pos  = !rem_in[TIME_BITS] && (rem_in != '0);
      rem_zero = (rem_in == '0);
      rem_x10  = ({4'b0, rem_in[TIME_BITS-1:0]} << 3) + ({4'b0, rem_in[TIME_BITS-1:0]} << 1);
      cyc_x7   = ({4'b0, cyc_in} << 3) - {4'b0, cyc_in};
      cyc_x2   = {4'b0, cyc_in} << 1;

      if (abort_in) begin
         lvl_in = wcc_pkg::LVL_OFF;
         run_in = 1'b0;
      end else if (run_in) begin
         if (rem_pos) begin
            if (rem_x10 > cyc_x7) begin
               lvl_in = wcc_pkg::LVL_LOW;
            end else if (rem_x10 > cyc_x2) begin
               lvl_in = wcc_pkg::LVL_MED;
            end else begin
               lvl_in = wcc_pkg::LVL_FULL;
            end
         end else if (rem_zero) begin
            lvl_in  = wcc_pkg::LVL_OFF;
            rem_in  = '1;
            run_in  = 1'b0;
            done_in = 1'b1;
         end
         // negative time after completion: level holds
      end else begin
         lvl_in = wcc_pkg::LVL_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_time_ff  <= TIME_BITS'(wcc_pkg::SHORT_TIME_RESET);
         medium_time_ff <= TIME_BITS'(wcc_pkg::MEDIUM_TIME_RESET);
         long_time_ff   <= TIME_BITS'(wcc_pkg::LONG_TIME_RESET);
         in_vld_ff      <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         door_ff        <= 1'b0;
         fill_ff        <= 1'b0;
         run_ff         <= 1'b0;
         abort_ff       <= 1'b0;
         done_ff        <= 1'b0;
         rem_ff         <= (TIME_BITS+1)'(wcc_pkg::CYCLE_TIME_RESET);
         cyc_ff         <= TIME_BITS'(wcc_pkg::CYCLE_TIME_RESET);
         idx_ff         <= 2'd0;
         lvl_ff         <= wcc_pkg::LVL_OFF;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wcc_pkg::CSR_SHORT_TIME:  short_time_ff  <= csr_data;
               wcc_pkg::CSR_MEDIUM_TIME: medium_time_ff <= csr_data;
               wcc_pkg::CSR_LONG_TIME:   long_time_ff   <= csr_data;
               default: ;
            endcase
         end
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            door_ff  <= door_in;
            fill_ff  <= fill_in;
            run_ff   <= run_in;
            abort_ff <= abort_in;
            done_ff  <= done_in;
            rem_ff   <= rem_in;
            cyc_ff   <= cyc_in;
            idx_ff   <= idx_in;
            lvl_ff   <= lvl_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_operation;
         in_time_ff <= req_new_time;
      end
      if (advance) begin
         rsp_motor_level      <= lvl_in;
         rsp_running          <= run_in;
         rsp_door_closed      <= door_in;
         rsp_detergent_filled <= fill_in;
         rsp_aborted          <= abort_in;
         rsp_completed        <= done_in;
         rsp_time_left        <= rem_in;
         rsp_total_time       <= cyc_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_abort_sticky: assert property (@(posedge clock) disable iff (reset)
      abort_ff |=> abort_ff)
      else $error("abort flag cleared without reset");

   a_idle_motor_off: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_running |-> rsp_motor_level == wcc_pkg::LVL_OFF)
      else $error("motor on while not running");

   a_abort_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_aborted |-> !rsp_running)
      else $error("running after abort");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_op_ff) && $stable(in_time_ff))
      else $error("stalled request lost");
`endif

endmodule

// ===== sim/wash_cycle_checker.sv =====
// Washer controller checker: snoops the request, response and register write
// channels, predicts every response and compares it field by field.
// Depends on wcc_pkg.

module wash_cycle_checker #(
   parameter int TIME_BITS = wcc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [wcc_pkg::OP_BITS-1:0]          req_operation,
   input  logic [TIME_BITS-1:0]                 req_new_time,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [wcc_pkg::LEVEL_BITS-1:0]       rsp_motor_level,
   input  logic                                 rsp_running,
   input  logic                                 rsp_door_closed,
   input  logic                                 rsp_detergent_filled,
   input  logic                                 rsp_aborted,
   input  logic                                 rsp_completed,
   input  logic signed [TIME_BITS:0]            rsp_time_left,
   input  logic [TIME_BITS-1:0]                 rsp_total_time,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [wcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [TIME_BITS-1:0]                 csr_data,
   output int                                   fail_count,
   output int                                   pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      wcc_pkg::level_type     level;
      logic                   running;
      logic                   door;
      logic                   detergent;
      logic                   aborted;
      logic                   completed;
      logic [TIME_BITS:0]     left;
      logic [TIME_BITS-1:0]   total;
   } washer_status_type;

   washer_status_type status_q[$];
   int                errors = 0;

   // predicted machine state
   logic      door_shut, soap_in, spinning, halted, finished;
   int        ticks_left, cycle_len;
   logic [1:0] slot;
   wcc_pkg::level_type motor;
   int        cycle_table [3];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic reset_washer();
      cycle_table[0] = wcc_pkg::SHORT_TIME_RESET;
      cycle_table[1] = wcc_pkg::MEDIUM_TIME_RESET;
      cycle_table[2] = wcc_pkg::LONG_TIME_RESET;
      door_shut  = 1'b0;
      soap_in    = 1'b0;
      spinning   = 1'b0;
      halted     = 1'b0;
      finished   = 1'b0;
      ticks_left = wcc_pkg::CYCLE_TIME_RESET;
      cycle_len  = wcc_pkg::CYCLE_TIME_RESET;
      slot       = 2'd0;
      motor      = wcc_pkg::LVL_OFF;
   endtask

   function automatic logic may_run();
      return !halted && soap_in && door_shut;
   endfunction

   task automatic apply_request(input logic [wcc_pkg::OP_BITS-1:0] op,
                                input logic [TIME_BITS-1:0] nt,
                                output washer_status_type st);
      int r10;
      case (op)
         wcc_pkg::OP_TICK:
            if (!halted && spinning && ticks_left > 0) ticks_left--;
         wcc_pkg::OP_SELECT_CYCLE:
            if (!halted) begin
               if (slot > 2'd2) slot = 2'd0;
               cycle_len  = cycle_table[slot];
               ticks_left = cycle_len;
               slot       = slot + 2'd1;
            end
         wcc_pkg::OP_TOGGLE_DOOR:
            if (!halted && !spinning) door_shut = !door_shut;
         wcc_pkg::OP_OPEN_DOOR:
            if (!spinning) door_shut = 1'b0;
         wcc_pkg::OP_CLOSE_DOOR:
            door_shut = 1'b1;
         wcc_pkg::OP_FILL:
            if (!halted && !door_shut && !spinning) soap_in = 1'b1;
         wcc_pkg::OP_ABORT: begin
            halted     = 1'b1;
            spinning   = 1'b0;
            ticks_left = 0;
         end
         wcc_pkg::OP_START:
            if (!finished && may_run()) spinning = 1'b1;
         wcc_pkg::OP_PAUSE:
            if (!halted) spinning = 1'b0;
         wcc_pkg::OP_RESUME:
            if (may_run()) spinning = 1'b1;
         wcc_pkg::OP_PAUSE_SWITCH:
            if (spinning) spinning = 1'b0;
            else if (may_run()) spinning = 1'b1;
         wcc_pkg::OP_SET_TIME: begin
            cycle_len  = int'(nt);
            ticks_left = cycle_len;
         end
         default: ;
      endcase

      // main-loop rule: 0.7 and 0.2 of the total as exact compares
      if (halted) begin
         motor    = wcc_pkg::LVL_OFF;
         spinning = 1'b0;
      end else if (spinning) begin
         if (ticks_left > 0) begin
            r10 = ticks_left * 10;
            if (r10 > 7 * cycle_len)      motor = wcc_pkg::LVL_LOW;
            else if (r10 > 2 * cycle_len) motor = wcc_pkg::LVL_MED;
            else                          motor = wcc_pkg::LVL_FULL;
         end else if (ticks_left == 0) begin
            motor      = wcc_pkg::LVL_OFF;
            ticks_left = -1;
            spinning   = 1'b0;
            finished   = 1'b1;
         end
         // negative time after resuming a finished cycle: level holds
      end else begin
         motor = wcc_pkg::LVL_OFF;
      end

      st.level     = motor;
      st.running   = spinning;
      st.door      = door_shut;
      st.detergent = soap_in;
      st.aborted   = halted;
      st.completed = finished;
      st.left      = ticks_left[TIME_BITS:0];
      st.total     = cycle_len[TIME_BITS-1:0];
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      washer_status_type want;
      if (reset) begin
         reset_washer();
         status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = status_q.pop_front();
               check_field("motor_level", want.level, rsp_motor_level);
               check_field("running", want.running, rsp_running);
               check_field("door_closed", want.door, rsp_door_closed);
               check_field("detergent_filled", want.detergent, rsp_detergent_filled);
               check_field("aborted", want.aborted, rsp_aborted);
               check_field("completed", want.completed, rsp_completed);
               check_field("time_left", $signed(want.left), rsp_time_left);
               check_field("total_time", want.total, rsp_total_time);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wcc_pkg::CSR_SHORT_TIME:  cycle_table[0] = int'(csr_data);
               wcc_pkg::CSR_MEDIUM_TIME: cycle_table[1] = int'(csr_data);
               wcc_pkg::CSR_LONG_TIME:   cycle_table[2] = int'(csr_data);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            apply_request(req_operation, req_new_time, want);
            status_q.push_back(want);
         end
      end
      pending    = status_q.size();
      fail_count = errors;
   end

endmodule

// ===== sim/wash_cycle_controller_top_tb.sv =====
// Washer controller testbench top: clock, reset, request and register write
// stimulus, response back-pressure, watchdog and verdict.
// Depends on wcc_pkg, wash_cycle_controller_top and wash_cycle_checker.

module wash_cycle_controller_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_BITS      = wcc_pkg::TIME_BITS_DEFAULT;
   localparam int TIME_MAX       = (1 << TIME_BITS) - 1;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [wcc_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [wcc_pkg::OP_BITS-1:0]          req_operation = wcc_pkg::OP_TICK;
   logic [TIME_BITS-1:0]                 req_new_time = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [wcc_pkg::LEVEL_BITS-1:0]       rsp_motor_level;
   logic                                 rsp_running;
   logic                                 rsp_door_closed;
   logic                                 rsp_detergent_filled;
   logic                                 rsp_aborted;
   logic                                 rsp_completed;
   logic signed [TIME_BITS:0]            rsp_time_left;
   logic [TIME_BITS-1:0]                 rsp_total_time;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [wcc_pkg::CSR_INDEX_BITS-1:0]   csr_index = wcc_pkg::CSR_SHORT_TIME;
   logic [TIME_BITS-1:0]                 csr_data = '0;

   int fail_count;
   int pending;
   int requests_sent = 0;
   int idle_cycles = 0;
   bit no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wash_cycle_controller_top #(.TIME_BITS(TIME_BITS)) DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_operation, .req_new_time,
      .rsp_valid, .rsp_ready, .rsp_motor_level, .rsp_running, .rsp_door_closed,
      .rsp_detergent_filled, .rsp_aborted, .rsp_completed, .rsp_time_left,
      .rsp_total_time,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   wash_cycle_checker #(.TIME_BITS(TIME_BITS)) checker_inst (
      .clock, .reset,
      .req_valid, .req_ready, .req_operation, .req_new_time,
      .rsp_valid, .rsp_ready, .rsp_motor_level, .rsp_running, .rsp_door_closed,
      .rsp_detergent_filled, .rsp_aborted, .rsp_completed, .rsp_time_left,
      .rsp_total_time,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic logic [TIME_BITS-1:0] any_time();
      return TIME_BITS'($urandom_range(0, TIME_MAX));
   endfunction

   // mostly short cycles so that runs reach completion
   function automatic logic [TIME_BITS-1:0] cycle_time();
      if ($urandom_range(0, 15) == 0) return any_time();
      return TIME_BITS'($urandom_range(0, 40));
   endfunction

   // called and returns at a falling edge
   task automatic send_request(input logic [wcc_pkg::OP_BITS-1:0] op,
                               input logic [TIME_BITS-1:0] nt);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_new_time  <= nt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_op(input logic [wcc_pkg::OP_BITS-1:0] op);
      send_request(op, any_time());
   endtask

   task automatic write_csr(input logic [wcc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [TIME_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // a load, fill and run sequence with random content
   task automatic wash_sequence();
      int n;
      if ($urandom_range(0, 1) == 0) send_op(wcc_pkg::OP_PAUSE);
      send_op(wcc_pkg::OP_OPEN_DOOR);
      send_op(wcc_pkg::OP_FILL);
      send_op($urandom_range(0, 1) ? wcc_pkg::OP_CLOSE_DOOR : wcc_pkg::OP_TOGGLE_DOOR);
      case ($urandom_range(0, 3))
         0, 1: send_op(wcc_pkg::OP_SELECT_CYCLE);
         2:    send_request(wcc_pkg::OP_SET_TIME, cycle_time());
         default: ;
      endcase
      case ($urandom_range(0, 2))
         0: send_op(wcc_pkg::OP_START);
         1: send_op(wcc_pkg::OP_RESUME);
         default: send_op(wcc_pkg::OP_PAUSE_SWITCH);
      endcase
      n = $urandom_range(1, 30);
      repeat (n) begin
         case ($urandom_range(0, 19))
            0: send_op(wcc_pkg::OP_PAUSE);
            1: send_op(wcc_pkg::OP_RESUME);
            2: send_op(wcc_pkg::OP_PAUSE_SWITCH);
            3: send_op(wcc_pkg::OP_SELECT_CYCLE);
            4: send_request(wcc_pkg::OP_SET_TIME, cycle_time());
            5: send_op(wcc_pkg::OP_START);
            default: send_op(wcc_pkg::OP_TICK);
         endcase
      end
   endtask

   task automatic noise_burst();
      logic [wcc_pkg::OP_BITS-1:0] op;
      repeat ($urandom_range(1, 8)) begin
         op = wcc_pkg::OP_BITS'($urandom_range(0, 15));
         // abort latches for good, so it is kept for the last phase
         if (op == wcc_pkg::OP_ABORT) op = wcc_pkg::OP_TICK;
         if (op == wcc_pkg::OP_SET_TIME && $urandom_range(0, 1)) send_request(op, cycle_time());
         else send_request(op, any_time());
      end
   endtask

   // response side back-pressure
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: door, detergent, levels, completion, resume after completion
      send_request(wcc_pkg::OP_TICK, TIME_BITS'(TIME_MAX));
      send_op(4'd12);
      send_op(4'd15);
      send_request(wcc_pkg::OP_SET_TIME, '0);
      send_request(wcc_pkg::OP_SET_TIME, TIME_BITS'(TIME_MAX));
      send_op(wcc_pkg::OP_TOGGLE_DOOR);
      send_op(wcc_pkg::OP_FILL);                     // door closed: refused
      send_op(wcc_pkg::OP_TOGGLE_DOOR);
      send_op(wcc_pkg::OP_START);                    // no detergent yet
      send_op(wcc_pkg::OP_FILL);
      send_op(wcc_pkg::OP_START);                    // door open
      send_op(wcc_pkg::OP_CLOSE_DOOR);
      send_op(wcc_pkg::OP_SELECT_CYCLE);
      send_op(wcc_pkg::OP_START);
      send_op(wcc_pkg::OP_OPEN_DOOR);                // ignored while running
      send_op(wcc_pkg::OP_TOGGLE_DOOR);
      send_op(wcc_pkg::OP_PAUSE_SWITCH);
      send_op(wcc_pkg::OP_PAUSE_SWITCH);
      send_request(wcc_pkg::OP_SET_TIME, TIME_BITS'(3));
      repeat (3) send_op(wcc_pkg::OP_TICK);          // medium, medium, then done
      send_op(wcc_pkg::OP_START);                    // refused once completed
      send_op(wcc_pkg::OP_RESUME);                   // runs on negative time
      send_op(wcc_pkg::OP_TICK);
      send_op(wcc_pkg::OP_PAUSE);
      send_op(wcc_pkg::OP_SELECT_CYCLE);
      send_op(wcc_pkg::OP_RESUME);
      send_request(wcc_pkg::OP_SET_TIME, '0);        // zero time while running
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               write_csr(wcc_pkg::CSR_SHORT_TIME, '0);
               write_csr(wcc_pkg::CSR_MEDIUM_TIME, '0);
               write_csr(wcc_pkg::CSR_LONG_TIME, '0);
            end
            1: begin
               write_csr(wcc_pkg::CSR_SHORT_TIME, TIME_BITS'(TIME_MAX));
               write_csr(wcc_pkg::CSR_MEDIUM_TIME, TIME_BITS'(TIME_MAX));
               write_csr(wcc_pkg::CSR_LONG_TIME, TIME_BITS'(TIME_MAX));
            end
            default: begin
               write_csr(wcc_pkg::CSR_SHORT_TIME, TIME_BITS'($urandom_range(1, 20)));
               write_csr(wcc_pkg::CSR_MEDIUM_TIME, cycle_time());
               write_csr(wcc_pkg::CSR_LONG_TIME, any_time());
            end
         endcase
         write_csr(CSR_SPARE, any_time());
         while (requests_sent < 26 + (p + 1) * ITEMS_PER_PHASE) begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 7) wash_sequence();
            else noise_burst();
         end
         no_idle = 1'b0;
         drain();
      end

      // abort latches until reset, so it comes last
      send_op(wcc_pkg::OP_ABORT);
      for (int op = 0; op < 16; op++) send_op(wcc_pkg::OP_BITS'(op));
      send_op(wcc_pkg::OP_ABORT);
      drain();
      repeat (8) @(negedge clock);

      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
